// ===== src/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg: shared types and constants for lens flare placement
// Opcodes, fixed-point constants and the queue entry between front and back.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam logic [1:0] OP_VIEW  = 2'd0;
  localparam logic [1:0] OP_PROJ  = 2'd1;
  localparam logic [1:0] OP_LIGHT = 2'd2;

  localparam logic signed [33:0] ONE_Q16  = 34'sd65536;
  localparam logic signed [33:0] HALF_Q16 = 34'sd32768;

  // one light that passed all tests, handed from front to back
  typedef struct packed {
    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [16:0]        bright;
  } lfp_job_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

endpackage

// ===== src/lfp_div.sv =====
// ----------------------------------------------------------------------------
// lfp_div: signed restoring divider
// Computes trunc(num / den) one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lfp_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [47:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [47:0] quo
);
  import lfp_pkg::*;

  logic [47:0] q;
  logic [47:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;

  assign trial = {rem[47:0], q[47]} - {17'd0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num[47] ? 48'(-num) : num;
        dmag <= den[31] ? 32'(-den) : den;
        neg  <= num[47] ^ den[31];
        rem  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], q[47]};
          q   <= {q[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? 48'(-q) : q;

endmodule

// ===== src/lfp_front.sv =====
// ----------------------------------------------------------------------------
// lfp_front: matrix store, transform, divide and brightness
// Loads rows, carries a light through both matrices and classifies it.
// ----------------------------------------------------------------------------
module lfp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [1:0]           row_index,
  input  logic signed [31:0]   elem_0,
  input  logic signed [31:0]   elem_1,
  input  logic signed [31:0]   elem_2,
  input  logic signed [31:0]   elem_3,
  input  logic signed [31:0]   light_x,
  input  logic signed [31:0]   light_y,
  input  logic signed [31:0]   light_z,
  output logic                 job_valid,
  output lfp_pkg::lfp_job_t    job,
  input  logic                 job_full
);
  import lfp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_DIVX, S_WX, S_DIVY, S_WY, S_SQ, S_SQRT, S_BR, S_PUSH
  } state_t;

  state_t state;
  logic signed [31:0] view_m [4][4];
  logic signed [31:0] proj_m [4][4];
  logic signed [31:0] vec [4];
  logic signed [31:0] res [4];
  logic               pass;   // 0 view, 1 projection
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [63:0] prod;
  logic signed [49:0] acc;
  logic signed [31:0] msel;
  logic signed [47:0] ndcx;
  logic signed [48:0] sx, sy;
  logic signed [33:0] dx, dy;
  logic [33:0]        sqx;
  logic [34:0]        sqsum;
  logic [35:0]        root;
  logic [35:0]        bitv;
  logic [35:0]        sq_nn;
  logic [4:0]         sq_cnt;
  logic [16:0]        bright;
  logic               dstart, ddone;
  logic signed [47:0] dnum, dquo;
  logic signed [31:0] dden;
  logic [35:0]        sq_t;
  logic [21:0]        lenx10;
  logic [41:0]        lq_prod;
  logic [21:0]        lq;

  assign msel     = pass ? proj_m[row][col] : view_m[row][col];
  assign in_stall = (state != S_IDLE);
  assign sq_t     = sq_nn - (root + bitv);

  lfp_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  // len * 10 / 7 by reciprocal multiplication, exact for len * 10 below 2^19
  always_comb begin
    lenx10  = 22'(root) * 22'd10;
    lq_prod = 42'(lenx10) * 42'd599187;
    lq      = 22'(lq_prod >> 22);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_valid <= 1'b0;
      dstart    <= 1'b0;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          view_m[r][c] <= '0;
          proj_m[r][c] <= '0;
        end
    end else begin
      dstart    <= 1'b0;
      job_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          if (opcode == OP_VIEW) begin
            view_m[row_index] <= '{elem_0, elem_1, elem_2, elem_3};
          end else if (opcode == OP_PROJ) begin
            proj_m[row_index] <= '{elem_0, elem_1, elem_2, elem_3};
          end else if (opcode == OP_LIGHT) begin
            vec   <= '{light_x, light_y, light_z, 32'sd65536};
            pass  <= 1'b0;
            row   <= 2'd0;
            col   <= 2'd0;
            acc   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 64'(msel) * 64'(vec[col]);
          state <= S_ACC;
        end
        S_ACC: begin
          if (col == 2'd3) begin
            res[row] <= sat32(66'(acc) + 66'(prod >>> 16));
            acc      <= '0;
            if (row == 2'd3) begin
              if (!pass) begin
                vec[0] <= res[0]; vec[1] <= res[1]; vec[2] <= res[2];
                vec[3] <= sat32(66'(acc) + 66'(prod >>> 16));
                pass   <= 1'b1;
                state  <= S_MUL;
              end else if (sat32(66'(acc) + 66'(prod >>> 16)) == 32'sd0) begin
                state <= S_IDLE;
              end else begin
                state <= S_DIVX;
              end
            end else begin
              state <= S_MUL;
            end
            row <= row + 2'd1;
          end else begin
            acc   <= acc + 50'(prod >>> 16);
            state <= S_MUL;
          end
          col <= col + 2'd1;
        end
        S_DIVX: begin
          dnum   <= {res[0], 16'd0};
          dden   <= res[3];
          dstart <= 1'b1;
          state  <= S_WX;
        end
        S_WX: if (ddone) begin
          ndcx   <= dquo;
          dnum   <= {res[1], 16'd0};
          dstart <= 1'b1;
          state  <= S_WY;
        end
        S_WY: if (ddone) begin
          sx    <= (49'(ndcx) + 49'sd65536) >>> 1;
          sy    <= 49'sd65536 - ((49'(dquo) + 49'sd65536) >>> 1);
          state <= S_DIVY;
        end
        S_DIVY: begin
          if (sx < 0 || sx > ONE_Q16 || sy < 0 || sy > ONE_Q16) begin
            state <= S_IDLE;
          end else begin
            dx    <= HALF_Q16 - 34'(sx);
            dy    <= HALF_Q16 - 34'(sy);
            sqx   <= 34'((HALF_Q16 - 34'(sx)) * (HALF_Q16 - 34'(sx)));
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sqsum  <= 35'(sqx) + 35'(34'(dy * dy));
          state  <= S_SQRT;
          root   <= '0;
          bitv   <= 36'h400000000;
          sq_cnt <= 5'd0;
        end
        S_SQRT: begin
          if (sq_cnt == 5'd0) sq_nn <= 36'(sqsum);
          else if (sq_nn >= root + bitv) begin
            sq_nn <= sq_t;
            root  <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          if (sq_cnt != 5'd0) bitv <= bitv >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd18) state <= S_BR;
        end
        S_BR: begin
          if (lq >= 22'd65536) state <= S_IDLE;
          else begin
            bright <= 17'(22'd65536 - lq);
            state  <= S_PUSH;
          end
        end
        S_PUSH: if (!job_full) begin
          job       <= '{sx: 34'(sx), sy: 34'(sy), dx: dx, dy: dy, bright: bright};
          job_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lfp_back.sv =====
// ----------------------------------------------------------------------------
// lfp_back: flare emitter
// Steps along the centre vector and emits one beat per flare.
// ----------------------------------------------------------------------------
module lfp_back #(
  parameter int FLARE_COUNT = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  lfp_pkg::lfp_job_t  job,
  output logic               job_take,
  input  logic [24:0]        spacing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         flare_index,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [16:0]        brightness,
  output logic               last
);
  import lfp_pkg::*;

  localparam int IW = $clog2(FLARE_COUNT + 1);

  logic              busy;
  logic [IW-1:0]     idx;
  logic signed [65:0] accx, accy;       // d * i * spacing
  logic signed [60:0] incx, incy;
  logic signed [43:0] mul_x, mul_y;
  lfp_job_t          cur;

  assign job_take = job_valid && !busy;

  // d fits in 18 signed bits once the light is on screen
  assign mul_x = $signed(job.dx[17:0]) * $signed({1'b0, spacing});
  assign mul_y = $signed(job.dy[17:0]) * $signed({1'b0, spacing});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        cur  <= job;
        busy <= 1'b1;
        idx  <= '0;
        accx <= '0;
        accy <= '0;
        incx <= 61'(mul_x);
        incy <= 61'(mul_y);
      end
      if (busy && (!out_valid || !out_stall)) begin
        out_valid   <= 1'b1;
        flare_index <= 4'(idx);
        pos_x       <= sat32(66'(cur.sx) + (accx >>> 16));
        pos_y       <= sat32(66'(cur.sy) + (accy >>> 16));
        brightness  <= cur.bright;
        last        <= (idx == IW'(FLARE_COUNT - 1));
        accx        <= accx + 66'(incx);
        accy        <= accy + 66'(incy);
        idx         <= idx + 1'b1;
        if (idx == IW'(FLARE_COUNT - 1)) busy <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/lens_flare_placement.sv =====
// A light beat passes through 32 multiply-accumulate steps, two 48-step divides,
// a square root, the queue and the emitter hand-over before its first flare beat.
// Matrix rows take one cycle each while the front is idle; a light that places
// flares holds the front until its job enters the queue (a dropped light frees it
// sooner), and its flares then leave one per cycle while out_stall is low.
// Reset (rst, synchronous) clears both matrices, spacing and all control state.
// ----------------------------------------------------------------------------
// lens_flare_placement: top level
// Front transforms and classifies lights; back emits flare beats.
// ----------------------------------------------------------------------------
module lens_flare_placement #(
  parameter int FLARE_COUNT = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [24:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] elem_0,
  input  logic signed [31:0] elem_1,
  input  logic signed [31:0] elem_2,
  input  logic signed [31:0] elem_3,
  input  logic signed [31:0] light_x,
  input  logic signed [31:0] light_y,
  input  logic signed [31:0] light_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         flare_index,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [16:0]        brightness,
  output logic               last
);
  import lfp_pkg::*;

  logic [24:0] flare_spacing;
  logic        fv, take;
  lfp_job_t    fj;
  // two-entry queue between front and back
  lfp_job_t    q [2];
  logic [1:0]  qcnt;
  logic        qrd, qwr;

  always_ff @(posedge clk) begin
    if (rst) flare_spacing <= '0;
    else if (cfg_we) flare_spacing <= cfg_data;
  end

  lfp_front u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .row_index,
    .elem_0, .elem_1, .elem_2, .elem_3, .light_x, .light_y, .light_z,
    .job_valid(fv), .job(fj), .job_full(qcnt == 2'd2)
  );

  // hold entry 0 at the head; advance on take
  always_ff @(posedge clk) begin
    if (rst) qcnt <= '0;
    else begin
      if (qwr && qcnt - 2'(qrd) == 2'd0) q[0] <= fj;
      else if (qrd) q[0] <= q[1];
      if (qwr && qcnt - 2'(qrd) == 2'd1) q[1] <= fj;
      qcnt <= qcnt + 2'(qwr) - 2'(qrd);
    end
  end
  assign qwr = fv;
  assign qrd = take;

  lfp_back #(.FLARE_COUNT(FLARE_COUNT)) u_back (
    .clk, .rst, .job_valid(qcnt != 2'd0), .job(q[0]), .job_take(take),
    .spacing(flare_spacing), .out_valid, .out_stall,
    .flare_index, .pos_x, .pos_y, .brightness, .last
  );

endmodule

// ===== src/lfp_checker.sv =====
// ----------------------------------------------------------------------------
// lfp_checker: port-level checks for lens flare placement
// Watches the output beat stream for stability and framing.
// ----------------------------------------------------------------------------
module lfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  flare_index,
  input logic        last,
  input logic [16:0] brightness
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(flare_index))
    else $error("stalled beat changed");
  a_bright: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> brightness != 17'd0)
    else $error("zero brightness beat");
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid || flare_index == 4'd0)
    else $error("flare run did not restart at zero");
endmodule

bind lens_flare_placement lfp_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .flare_index, .last, .brightness
);
